/* rtl/esa_pkg.sv */
// Shared types, constants and helpers for the encoder setpoint adjuster.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package esa_pkg;

	localparam int VOLTAGE_BITS = 10;
	localparam int CURRENT_BITS = 9;
	localparam int IDLE_BITS    = 8;
	localparam int CFG_DATA_BITS =
		(VOLTAGE_BITS >= CURRENT_BITS) ?
			((VOLTAGE_BITS >= IDLE_BITS) ? VOLTAGE_BITS : IDLE_BITS) :
			((CURRENT_BITS >= IDLE_BITS) ? CURRENT_BITS : IDLE_BITS);
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [IDLE_BITS-1:0] IDLE_SAT       = '1;
	localparam logic [IDLE_BITS-1:0] IDLE_LIMIT_RST = IDLE_BITS'(200);

	// event kinds
	localparam logic [1:0] OP_ENC  = 2'd0;
	localparam logic [1:0] OP_BTN  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// adjust modes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_VOLT = 2'd1;
	localparam logic [1:0] MODE_CURR = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLTAGE_MAX   = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_MAX   = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_LIMIT    = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_VOLTAGE = CFG_INDEX_BITS'(3);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_CURRENT = CFG_INDEX_BITS'(4);

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] encoder_code;
	} in_t;

	typedef struct packed {
		logic [VOLTAGE_BITS-1:0] voltage_setpoint;
		logic [CURRENT_BITS-1:0] current_setpoint;
		logic [1:0]              mode;
		logic                    store_pulse;
		logic                    setpoint_updated;
	} out_t;

	typedef struct packed {
		logic [VOLTAGE_BITS-1:0] voltage_max;
		logic [CURRENT_BITS-1:0] current_max;
		logic [IDLE_BITS-1:0]    idle_limit;
	} cfg_t;

	typedef struct packed {
		logic up;
		logic down;
	} step_t;

	// successor along the quadrature sequence 0,2,3,1
	function automatic logic [1:0] code_next(input logic [1:0] code);
		logic [1:0] nxt;
		unique case (code)
			2'd0: nxt = 2'd2;
			2'd1: nxt = 2'd0;
			2'd2: nxt = 2'd3;
			default: nxt = 2'd1;
		endcase
		return nxt;
	endfunction

	function automatic step_t step_dir(input logic [1:0] prev, input logic [1:0] now);
		step_t s;
		s.up   = (code_next(prev) == now);
		s.down = !s.up && (code_next(now) == prev);
		return s;
	endfunction

endpackage

/* rtl/esa_cfg.sv */
// Configuration register file: clamps and idle limit.
// Depends on esa_pkg.
`timescale 1ns / 1ps

module esa_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [esa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [esa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output esa_pkg::cfg_t                        cfg
);
	import esa_pkg::*;

	cfg_t cfg_q;

	// Start values only matter at reset, and reset clears them, so
	// writes to those two indexes are taken and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voltage_max <= '1;
			cfg_q.current_max <= '1;
			cfg_q.idle_limit  <= IDLE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VOLTAGE_MAX: cfg_q.voltage_max <= cfg_data[VOLTAGE_BITS-1:0];
				CFG_CURRENT_MAX: cfg_q.current_max <= cfg_data[CURRENT_BITS-1:0];
				CFG_IDLE_LIMIT:  cfg_q.idle_limit  <= cfg_data[IDLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/esa_core.sv */
// Adjuster state and its next-state logic for one event.
// Depends on esa_pkg.
`timescale 1ns / 1ps

module esa_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  esa_pkg::in_t  item,
	input  esa_pkg::cfg_t cfg,
	output esa_pkg::out_t result
);
	import esa_pkg::*;

	logic [VOLTAGE_BITS-1:0] voltage_q;
	logic [CURRENT_BITS-1:0] current_q;
	logic [1:0]              mode_q;
	logic [1:0]              last_code_q;
	logic [IDLE_BITS-1:0]    idle_q;
	logic                    armed_q;

	logic [1:0]              mode_a, mode_n;
	logic [IDLE_BITS-1:0]    idle_a, idle_n;
	logic                    armed_a, armed_n, fire;
	logic [VOLTAGE_BITS-1:0] voltage_n;
	logic [CURRENT_BITS-1:0] current_n;
	logic                    updated;
	step_t                   dir;
	logic [VOLTAGE_BITS:0]   v_cand;
	logic [CURRENT_BITS:0]   c_cand;
	logic                    v_neg, c_neg;

	assign dir = step_dir(last_code_q, item.encoder_code);

	// candidate setpoints; a step below zero is flagged apart
	always_comb begin
		v_neg  = dir.down && (voltage_q == '0);
		c_neg  = dir.down && (current_q == '0);
		v_cand = {1'b0, voltage_q};
		c_cand = {1'b0, current_q};
		if (dir.up) begin
			v_cand = {1'b0, voltage_q} + (VOLTAGE_BITS+1)'(1);
			c_cand = {1'b0, current_q} + (CURRENT_BITS+1)'(1);
		end else if (dir.down && !v_neg) begin
			v_cand = {1'b0, voltage_q} - (VOLTAGE_BITS+1)'(1);
		end
		if (dir.down && !c_neg)
			c_cand = {1'b0, current_q} - (CURRENT_BITS+1)'(1);
	end

	always_comb begin
		mode_a  = mode_q;
		idle_a  = idle_q;
		armed_a = armed_q;
		unique case (item.opcode)
			OP_BTN: begin
				armed_a = 1'b1;
				idle_a  = '0;
				mode_a  = (mode_q == MODE_VOLT) ? MODE_CURR :
					(mode_q == MODE_OFF) ? MODE_VOLT : MODE_OFF;
			end
			OP_TICK: begin
				if (idle_q != IDLE_SAT)
					idle_a = idle_q + IDLE_BITS'(1);
			end
			default: ;
		endcase

		fire    = armed_a && (idle_a > cfg.idle_limit);
		mode_n  = fire ? MODE_OFF : mode_a;
		armed_n = fire ? 1'b0 : armed_a;
		idle_n  = idle_a;

		voltage_n = voltage_q;
		current_n = current_q;
		updated   = 1'b0;
		if (item.opcode == OP_ENC) begin
			if (mode_n == MODE_VOLT) begin
				if (!v_neg && v_cand >= {1'b0, cfg.voltage_max})
					voltage_n = cfg.voltage_max;
				else
					voltage_n = v_neg ? '0 : v_cand[VOLTAGE_BITS-1:0];
			end
			if (mode_n == MODE_CURR) begin
				if (!c_neg && c_cand >= {1'b0, cfg.current_max})
					current_n = cfg.current_max;
				else
					current_n = c_neg ? '0 : c_cand[CURRENT_BITS-1:0];
			end
			if ((mode_n == MODE_VOLT || mode_n == MODE_CURR) &&
				item.encoder_code != last_code_q) begin
				updated = 1'b1;
				idle_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_q   <= '0;
			current_q   <= '0;
			mode_q      <= MODE_OFF;
			last_code_q <= '0;
			idle_q      <= '0;
			armed_q     <= 1'b0;
		end else if (advance) begin
			voltage_q <= voltage_n;
			current_q <= current_n;
			mode_q    <= mode_n;
			idle_q    <= idle_n;
			armed_q   <= armed_n;
			if (item.opcode == OP_ENC)
				last_code_q <= item.encoder_code;
		end
	end

	assign result.voltage_setpoint = voltage_n;
	assign result.current_setpoint = current_n;
	assign result.mode             = mode_n;
	assign result.store_pulse      = fire;
	assign result.setpoint_updated = updated;

	// a timeout always leaves the save disarmed
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && fire |=> !armed_q)
		else $error("save still armed after store pulse");

	// the idle counter and the mode hold while nothing is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(idle_q) && $stable(mode_q))
		else $error("state changed without an event");

	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("mode register reached an unused code");

endmodule

/* rtl/encoder_setpoint_adjuster.sv */
// An accepted event is held in the input register, then its result goes to the result
// register; the next-state logic between the two registers sets the pace.
// Throughput: one event per cycle while the output is not stalled.
// Stall on the input rises only when the input register holds a transaction and the result
// register is full and stalled.
// Reset (arst_n low, asynchronous): setpoints 0, mode off, idle count 0, save disarmed,
// clamps at full scale, idle limit 200. Configuration writes are always ready.
`timescale 1ns / 1ps

module encoder_setpoint_adjuster (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  esa_pkg::in_t                         in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output esa_pkg::out_t                        out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [esa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [esa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import esa_pkg::*;

	logic  valid_s1, valid_s2;
	in_t   item_s1;
	out_t  data_s2;
	out_t  result;
	cfg_t  cfg;
	logic  advance;

	assign cfg_ready = 1'b1;

	esa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	esa_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// move the held transaction on whenever the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (advance)
			data_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.store_pulse |-> out_data.mode == MODE_OFF)
		else $error("store pulse with mode not off");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.setpoint_updated |-> out_data.mode != MODE_OFF)
		else $error("setpoint update reported in mode off");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(item_s1))
		else $error("held transaction lost while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result register changed under stall");

endmodule
